>>> design/assert_macros.svh
// Assertion macros shared by the clipper RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> design/lswc_pkg.sv
package lswc_pkg;
  // region code bits
  localparam int unsigned CodeLeft  = 0;
  localparam int unsigned CodeRight = 1;
  localparam int unsigned CodeBelow = 2;
  localparam int unsigned CodeAbove = 3;
  localparam int unsigned MaxClips  = 4;

  // configuration register indexes
  localparam logic [1:0] RegLeft   = 2'd0;
  localparam logic [1:0] RegBottom = 2'd1;
  localparam logic [1:0] RegRight  = 2'd2;
  localparam logic [1:0] RegTop    = 2'd3;

  // divider handshake
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } lswc_div_ctl_t;
endpackage

>>> design/lswc_divider.sv
`include "assert_macros.svh"
// Unsigned restoring divider, one quotient bit per cycle.
module lswc_divider import lswc_pkg::*; #(
  parameter int unsigned NumWidth = 24,
  parameter int unsigned DenWidth = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NumWidth-1:0] num_i,
  input  logic [DenWidth-1:0] den_i,
  output lswc_div_ctl_t       ctl_o,
  output logic [NumWidth-1:0] quot_o
);
  localparam int unsigned CntWidth = $clog2(NumWidth + 1);
  localparam logic [CntWidth-1:0] CntFull = CntWidth'(NumWidth);

  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [NumWidth-1:0] quo_q, quo_d;
  logic [DenWidth:0]   rem_q, rem_d, shifted;
  logic [DenWidth-1:0] den_q, den_d;

  // shift-subtract step
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    shifted = {rem_q[DenWidth-1:0], quo_q[NumWidth-1]};
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CntFull;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
        quo_d = {quo_q[NumWidth-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[NumWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign ctl_o  = '{start: start_i, busy: busy_q, done: done_q};
  assign quot_o = quo_q;

  `ASSERT_IMPLY(a_done_not_busy, clk_i, rst_ni, done_q, !busy_q)
  `ASSERT_IMPLY(a_cnt_zero_idle, clk_i, rst_ni, !busy_q, cnt_q == '0)
  `ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_q, busy_q)
endmodule

>>> design/line_segment_window_clipper_core.sv
`include "assert_macros.svh"
// Cohen-Sutherland line clipper against a configurable window.
// Config: cfg_valid_i/cfg_ready_o with cfg_index_i (0 left, 1 bottom,
//   2 right, 3 top) and cfg_data_i; ready always high, write only when idle.
//   Other indexes are ignored.
// Items: raise start while busy is low with the four endpoint coords.
//   busy rises the next cycle; the result appears on the result ports
//   for one cycle with done_o high, and busy drops the cycle after that.
// Steps: a trivial accept or reject passes through a test and an output
//   state. Each edge move adds a test, a multiply, a divider launch, a wait
//   on the shared serial divider and a code update; a move with a zero
//   difference skips the divider launch and wait. Up to four moves.
// One item at a time: a new item is taken only in idle, after the last
//   result; the divider, one quotient bit per cycle, is the rate limit.
// Reset loads the window 0,0 .. 639,479 and returns to idle.
// The receiver cannot stall; results are taken on the done_o cycle.
module line_segment_window_clipper_core import lswc_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] start_x_i,
  input  logic signed [COORD_WIDTH-1:0] start_y_i,
  input  logic signed [COORD_WIDTH-1:0] end_x_i,
  input  logic signed [COORD_WIDTH-1:0] end_y_i,
  output logic                          done_o,
  output logic                          visible_o,
  output logic                          wholly_inside_o,
  output logic signed [COORD_WIDTH-1:0] clipped_start_x_o,
  output logic signed [COORD_WIDTH-1:0] clipped_start_y_o,
  output logic signed [COORD_WIDTH-1:0] clipped_end_x_o,
  output logic signed [COORD_WIDTH-1:0] clipped_end_y_o,
  output logic [3:0]                    start_region_o,
  output logic [3:0]                    end_region_o
);
  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 1;          // difference width
  localparam int unsigned PW = 2 * W + 2;      // product magnitude width
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StTest = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StWait = 3'd4;
  localparam logic [2:0] StUpd  = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic signed [W-1:0] win_l_q, win_b_q, win_r_q, win_t_q;
  logic [2:0] st_q, st_d;
  logic signed [W-1:0] x0_q, y0_q, x1_q, y1_q;
  logic [3:0] c0_q, c1_q, o0_q, o1_q;
  logic [2:0] n_q;
  logic       vis_q;
  logic       first_q, neg_q, yedge_q, zero_q;
  logic signed [W-1:0] edge_q, base_q;
  logic [DW-1:0] mda_q, mdb_q, mden_q;
  logic [PW-1:0] prod_q;

  // region code of one point
  function automatic logic [3:0] region(input logic signed [W-1:0] x,
      input logic signed [W-1:0] y, input logic signed [W-1:0] l,
      input logic signed [W-1:0] b, input logic signed [W-1:0] r,
      input logic signed [W-1:0] t);
    logic [3:0] c;
    c = '0;
    c[CodeAbove] = y > t;
    c[CodeBelow] = y < b;
    c[CodeRight] = x > r;
    c[CodeLeft]  = x < l;
    return c;
  endfunction

  function automatic logic [DW-1:0] magn(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  // configuration
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_l_q <= W'(0);
      win_b_q <= W'(0);
      win_r_q <= W'(639);
      win_t_q <= W'(479);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegLeft:   win_l_q <= cfg_data_i;
        RegBottom: win_b_q <= cfg_data_i;
        RegRight:  win_r_q <= cfg_data_i;
        RegTop:    win_t_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // shared divider
  lswc_div_ctl_t       div_ctl;
  logic [PW-1:0]       div_q;
  lswc_divider #(.NumWidth(PW), .DenWidth(DW)) u_div (
    .clk_i, .rst_ni,
    .start_i(st_q == StDiv),
    .num_i  (prod_q),
    .den_i  (mden_q),
    .ctl_o  (div_ctl),
    .quot_o (div_q)
  );

  // edge selection for the current test
  logic               sel_first;
  logic [3:0]         sel_c;
  logic signed [W-1:0] px, py, ox, oy;
  logic signed [DW-1:0] e_ext, a0, a1, b0, b1;
  logic               sel_y;
  logic signed [W-1:0] sel_edge;
  always_comb begin
    sel_first = c0_q != 4'd0;
    sel_c = sel_first ? c0_q : c1_q;
    px = sel_first ? x0_q : x1_q;
    py = sel_first ? y0_q : y1_q;
    ox = sel_first ? x1_q : x0_q;
    oy = sel_first ? y1_q : y0_q;
    priority if (sel_c[CodeAbove]) begin
      sel_y = 1'b1; sel_edge = win_t_q;
    end else if (sel_c[CodeBelow]) begin
      sel_y = 1'b1; sel_edge = win_b_q;
    end else if (sel_c[CodeRight]) begin
      sel_y = 1'b0; sel_edge = win_r_q;
    end else begin
      sel_y = 1'b0; sel_edge = win_l_q;
    end
    // a moves along, b is the axis of the edge
    a0 = DW'(sel_y ? px : py);
    a1 = DW'(sel_y ? ox : oy);
    b0 = DW'(sel_y ? py : px);
    b1 = DW'(sel_y ? oy : ox);
    e_ext = DW'(sel_edge);
  end

  logic signed [DW-1:0] da, db, den;
  assign da  = a1 - a0;
  assign db  = e_ext - b0;
  assign den = b1 - b0;

  // new point after division
  logic signed [W-1:0] newc, nx, ny;
  always_comb begin
    newc = neg_q ? W'(base_q - W'(div_q)) : W'(base_q + W'(div_q));
    if (zero_q) newc = base_q;
    nx = yedge_q ? newc : edge_q;
    ny = yedge_q ? edge_q : newc;
  end

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (start) st_d = StTest;
      StTest: begin
        if ((c0_q | c1_q) == 4'd0 || (c0_q & c1_q) != 4'd0 ||
            n_q >= 3'(MaxClips)) st_d = StOut;
        else st_d = StMul;
      end
      StMul:   st_d = zero_q ? StUpd : StDiv;
      StDiv:   st_d = StWait;
      StWait:  if (div_ctl.done) st_d = StUpd;
      StUpd:   st_d = StTest;
      StOut:   st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      n_q   <= '0;
      vis_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StIdle && start) begin
        n_q   <= '0;
        vis_q <= 1'b0;
      end else if (st_q == StTest) begin
        vis_q <= (c0_q | c1_q) == 4'd0;
      end else if (st_q == StUpd) begin
        n_q <= n_q + 3'd1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        x0_q <= start_x_i; y0_q <= start_y_i;
        x1_q <= end_x_i;   y1_q <= end_y_i;
        c0_q <= region(start_x_i, start_y_i, win_l_q, win_b_q, win_r_q, win_t_q);
        c1_q <= region(end_x_i, end_y_i, win_l_q, win_b_q, win_r_q, win_t_q);
        o0_q <= region(start_x_i, start_y_i, win_l_q, win_b_q, win_r_q, win_t_q);
        o1_q <= region(end_x_i, end_y_i, win_l_q, win_b_q, win_r_q, win_t_q);
      end
      StTest: begin
        first_q <= sel_first;
        yedge_q <= sel_y;
        edge_q  <= sel_edge;
        base_q  <= W'(a0);
        mda_q   <= magn(da);
        mdb_q   <= magn(db);
        mden_q  <= magn(den);
        zero_q  <= (den == '0) || (da == '0) || (db == '0);
        neg_q   <= ((da < 0) != (db < 0)) != (den < 0);
      end
      StMul: prod_q <= PW'(mda_q) * PW'(mdb_q);
      StUpd: begin
        if (first_q) begin
          x0_q <= nx; y0_q <= ny;
          c0_q <= region(nx, ny, win_l_q, win_b_q, win_r_q, win_t_q);
        end else begin
          x1_q <= nx; y1_q <= ny;
          c1_q <= region(nx, ny, win_l_q, win_b_q, win_r_q, win_t_q);
        end
      end
      default: ;
    endcase
  end

  // result
  assign busy              = st_q != StIdle;
  assign done_o            = st_q == StOut;
  assign visible_o         = vis_q;
  assign wholly_inside_o   = (o0_q | o1_q) == 4'd0;
  assign clipped_start_x_o = vis_q ? x0_q : '0;
  assign clipped_start_y_o = vis_q ? y0_q : '0;
  assign clipped_end_x_o   = vis_q ? x1_q : '0;
  assign clipped_end_y_o   = vis_q ? y1_q : '0;
  assign start_region_o    = o0_q;
  assign end_region_o      = o1_q;

  `ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o && !busy)
  `ASSERT_IMPLY(a_clip_bound, clk_i, rst_ni, busy, n_q <= 3'(MaxClips))
  `ASSERT_IMPLY(a_div_only_wait, clk_i, rst_ni, div_ctl.busy, st_q == StWait)
  `ASSERT_IMPLY(a_inside_vis, clk_i, rst_ni, done_o && wholly_inside_o, visible_o)
endmodule

>>> tb/line_segment_window_clipper_checker.sv
module line_segment_window_clipper_checker import lswc_pkg::*; #(
  parameter int unsigned CW = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [CW-1:0]        cfg_data_i,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic signed [CW-1:0] start_x_i,
  input  logic signed [CW-1:0] start_y_i,
  input  logic signed [CW-1:0] end_x_i,
  input  logic signed [CW-1:0] end_y_i,
  input  logic                 done_i,
  input  logic                 visible_i,
  input  logic                 wholly_inside_i,
  input  logic signed [CW-1:0] clipped_start_x_i,
  input  logic signed [CW-1:0] clipped_start_y_i,
  input  logic signed [CW-1:0] clipped_end_x_i,
  input  logic signed [CW-1:0] clipped_end_y_i,
  input  logic [3:0]           start_region_i,
  input  logic [3:0]           end_region_i,
  output int                   fail_cnt_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic          vis;
    logic          whole;
    logic [CW-1:0] sx, sy, ex, ey;
    logic [3:0]    sreg, ereg;
  } clip_res_t;

  longint win_l, win_b, win_r, win_t;
  clip_res_t clip_q[$];

  function automatic longint sx_coord(logic [CW-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [3:0] outcode(longint x, longint y);
    logic [3:0] c;
    c = '0;
    c[CodeAbove] = y > win_t;
    c[CodeBelow] = y < win_b;
    c[CodeRight] = x > win_r;
    c[CodeLeft]  = x < win_l;
    return c;
  endfunction

  // a0 + trunc((a1-a0)*(edge-b0)/(b1-b0)); SV division truncates toward zero
  function automatic longint edge_cross(longint a0, longint b0, longint a1, longint b1,
                                        longint e);
    if (b1 == b0) return a0;
    return a0 + ((a1 - a0) * (e - b0)) / (b1 - b0);
  endfunction

  function automatic clip_res_t clip_segment(longint x0, longint y0, longint x1,
                                             longint y1);
    clip_res_t r;
    logic [3:0] c0, c1, c;
    longint px, py, ox, oy, nx, ny;
    bit vis, first;
    c0 = outcode(x0, y0);
    c1 = outcode(x1, y1);
    r.sreg = c0;
    r.ereg = c1;
    r.whole = (c0 | c1) == 0;
    vis = 0;
    for (int n = 0; ; n++) begin
      if ((c0 | c1) == 0) begin
        vis = 1;
        break;
      end
      if ((c0 & c1) != 0 || n >= MaxClips) break;
      first = c0 != 0;
      c = first ? c0 : c1;
      px = first ? x0 : x1; py = first ? y0 : y1;
      ox = first ? x1 : x0; oy = first ? y1 : y0;
      if (c[CodeAbove]) begin
        ny = win_t; nx = edge_cross(px, py, ox, oy, ny);
      end else if (c[CodeBelow]) begin
        ny = win_b; nx = edge_cross(px, py, ox, oy, ny);
      end else if (c[CodeRight]) begin
        nx = win_r; ny = edge_cross(py, px, oy, ox, nx);
      end else begin
        nx = win_l; ny = edge_cross(py, px, oy, ox, nx);
      end
      if (first) begin
        x0 = nx; y0 = ny; c0 = outcode(x0, y0);
      end else begin
        x1 = nx; y1 = ny; c1 = outcode(x1, y1);
      end
    end
    r.vis = vis;
    r.sx = vis ? CW'(x0) : '0;
    r.sy = vis ? CW'(y0) : '0;
    r.ex = vis ? CW'(x1) : '0;
    r.ey = vis ? CW'(y1) : '0;
    return r;
  endfunction

  assign pending_o = clip_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    clip_res_t got, want;
    if (!rst_ni) begin
      win_l <= 0; win_b <= 0; win_r <= 639; win_t <= 479;
      clip_q.delete();
      fail_cnt_o <= 0;
    end else begin
      // result first: a result never shares an edge with its own item
      if (done_i) begin
        got = '{visible_i, wholly_inside_i, clipped_start_x_i, clipped_start_y_i,
                clipped_end_x_i, clipped_end_y_i, start_region_i, end_region_i};
        if (clip_q.size() == 0) begin
          if (fail_cnt_o < 10) $display("clip result with no item pending: %p", got);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = clip_q.pop_front();
          if (got !== want) begin
            if (fail_cnt_o < 10) $display("clip result wrong: exp %p got %p", want, got);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      if (start_i && !busy_i)
        clip_q.push_back(clip_segment(sx_coord(start_x_i), sx_coord(start_y_i),
                                      sx_coord(end_x_i), sx_coord(end_y_i)));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegLeft:   win_l <= sx_coord(cfg_data_i);
          RegBottom: win_b <= sx_coord(cfg_data_i);
          RegRight:  win_r <= sx_coord(cfg_data_i);
          RegTop:    win_t <= sx_coord(cfg_data_i);
          default: ;
        endcase
      end
    end
  end
endmodule

>>> tb/line_segment_window_clipper_core_tb.sv
module line_segment_window_clipper_core_tb import lswc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = 12;
  localparam int WatchLimit = 20000;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_valid_i = 0, cfg_ready_o;
  logic [1:0] cfg_index_i = RegLeft;
  logic [CW-1:0] cfg_data_i = '0;
  logic start = 0, busy;
  logic signed [CW-1:0] sx = '0, sy = '0, ex = '0, ey = '0;
  logic done_o, visible_o, wholly_inside_o;
  logic signed [CW-1:0] csx, csy, cex, cey;
  logic [3:0] sreg, ereg;
  int fail_cnt, pending, idle_cycles;
  logic signed [CW-1:0] wl, wb, wr, wt;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  line_segment_window_clipper_core #(.COORD_WIDTH(CW)) u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .start, .busy, .start_x_i(sx), .start_y_i(sy), .end_x_i(ex), .end_y_i(ey),
    .done_o, .visible_o, .wholly_inside_o, .clipped_start_x_o(csx),
    .clipped_start_y_o(csy), .clipped_end_x_o(cex), .clipped_end_y_o(cey),
    .start_region_o(sreg), .end_region_o(ereg));

  line_segment_window_clipper_checker #(.CW(CW)) u_chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .start_i(start), .busy_i(busy), .start_x_i(sx), .start_y_i(sy),
    .end_x_i(ex), .end_y_i(ey), .done_i(done_o), .visible_i(visible_o),
    .wholly_inside_i(wholly_inside_o), .clipped_start_x_i(csx),
    .clipped_start_y_i(csy), .clipped_end_x_i(cex), .clipped_end_y_i(cey),
    .start_region_i(sreg), .end_region_i(ereg), .fail_cnt_o(fail_cnt),
    .pending_o(pending));

  // watchdog: cycles with no item, result or register write accepted
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("line_segment_window_clipper_core: mismatch");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [CW-1:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic set_window(logic signed [CW-1:0] l, b, r, t);
    wl = l; wb = b; wr = r; wt = t;
    write_reg(RegLeft, l);
    write_reg(RegBottom, b);
    write_reg(RegRight, r);
    write_reg(RegTop, t);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk_i);
  endtask

  // one segment; start stays high until the block takes it
  task automatic send_segment(logic signed [CW-1:0] x0, y0, x1, y1);
    start <= 1;
    sx <= x0; sy <= y0; ex <= x1; ey <= y1;
    do @(posedge clk_i); while (busy);
    start <= 0;
    // block stays busy through its test and output states after taking an item
    @(posedge clk_i);
    idle_gap();
  endtask

  // wait for all results, then let the block settle before a register write
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (130) @(posedge clk_i);
  endtask

  function automatic logic signed [CW-1:0] rnd_coord();
    return CW'($urandom);
  endfunction

  // coordinate near the window: inside, on an edge, or a little outside
  function automatic logic signed [CW-1:0] near(logic signed [CW-1:0] lo, hi);
    int lo_i, hi_i;
    lo_i = lo; hi_i = hi;
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      2: return CW'(lo_i - $urandom_range(1, 200));
      3: return CW'(hi_i + $urandom_range(1, 200));
      default: return (hi_i >= lo_i) ? CW'(lo_i + $urandom_range(0, hi_i - lo_i)) : rnd_coord();
    endcase
  endfunction

  task automatic random_burst(int count);
    repeat (count) begin
      if ($urandom_range(0, 4) == 0)
        send_segment(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
      else
        send_segment(near(wl, wr), near(wb, wt), near(wl, wr), near(wb, wt));
    end
  endtask

  initial begin
    wl = 0; wb = 0; wr = 639; wt = 479;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed, reset window
    send_segment(10, 10, 600, 400);         // wholly inside
    send_segment(-2048, -2048, 2047, 2047); // extremes, diagonal clip
    send_segment(-2048, 2047, 2047, -2048);
    send_segment(-100, 500, -50, 900);      // trivial reject
    send_segment(700, 100, -100, 100);      // both ends moved
    send_segment(320, 2047, 320, -2048);    // vertical through
    send_segment(5, 5, 5, 5);               // zero length inside
    send_segment(-5, -5, -5, -5);           // zero length outside
    send_segment(0, 0, 639, 479);           // exactly on corners
    send_segment(-10, 470, 20, 500);        // corner miss region
    send_segment(2047, 2047, 2047, 2047);
    drain();
    // inverted window
    set_window(100, 100, -100, -100);
    send_segment(0, 0, 10, 10);
    send_segment(-2048, -2048, 2047, 2047);
    send_segment(50, 0, -50, 0);
    drain();
    // full-range and minimal windows, ignored index handled in checker
    set_window(-2048, -2048, 2047, 2047);
    send_segment(-2048, -2048, 2047, 2047);
    send_segment(-2048, 2047, 2047, -2048);
    drain();
    set_window(7, -3, 7, -3);
    send_segment(0, -10, 14, 4);
    send_segment(7, -3, 7, -3);
    drain();

    // random phases with differing windows
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_window(0, 0, 639, 479);
        1: set_window(-2048, -2048, 2047, 2047);
        2: set_window(-300, -200, 300, 200);
        3: set_window(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
        default: begin
          int a, b;
          a = $urandom_range(0, 3000) - 1500;
          b = $urandom_range(0, 3000) - 1500;
          set_window(CW'(a), CW'(b), CW'(a + $urandom_range(0, 500)),
                     CW'(b + $urandom_range(0, 500)));
        end
      endcase
      random_burst(145);
      drain();
    end

    while (pending != 0) @(posedge clk_i);
    repeat (130) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("line_segment_window_clipper_core: match");
    else
      $display("line_segment_window_clipper_core: mismatch");
    $finish;
  end
endmodule
